>>> design/rcma_pkg.sv
// ----------------------------------------------------------------------------
// rcma_pkg
// Shared types and constants of the range-checked moving average.
// ----------------------------------------------------------------------------
package rcma_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // register indexes of the configuration channel
    localparam cfg_idx_t REG_UPPER = 2'd0;
    localparam cfg_idx_t REG_LOWER = 2'd1;

    // limit reset values: 100.0 and -40.0 in Q8.8
    localparam sample_t UPPER_RESET = 16'sd25600;
    localparam sample_t LOWER_RESET = -16'sd10240;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic ram_re;
        logic ram_we;
        logic div_start;
        logic load_out;
    } ctrl_t;

endpackage

>>> design/rcma_if.sv
// ----------------------------------------------------------------------------
// rcma channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface rcma_sample_if;
    logic               valid;
    logic               ready;
    rcma_pkg::sample_t  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rcma_result_if;
    logic               valid;
    logic               ready;
    rcma_pkg::sample_t  average;
    logic               rejected;

    modport source (output valid, output average, output rejected, input ready);
    modport sink   (input valid, input average, input rejected, output ready);
endinterface

interface rcma_cfg_if;
    logic               valid;
    logic               ready;
    rcma_pkg::cfg_idx_t index;
    rcma_pkg::sample_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/rcma_ram.sv
// ----------------------------------------------------------------------------
// rcma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rcma_div.sv
// ----------------------------------------------------------------------------
// rcma_div
// Bit-serial restoring divider: signed sum by unsigned nonzero count,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcma_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [ITER_W-1:0]   iter_reg,  iter_next;
    logic [CNT_W:0]      rem_reg,   rem_next;
    logic [SUM_W-1:0]    quo_reg,   quo_next;
    logic [CNT_W-1:0]    dvs_reg,   dvs_next;
    logic                neg_reg,   neg_next;

    logic [CNT_W:0]      rem_shift;
    logic                fits;

    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (SUM_W'(0) - quo_reg) : quo_reg;

endmodule

>>> design/range_checked_moving_average.sv
// ----------------------------------------------------------------------------
// range_checked_moving_average
// Limit check and moving average over signed Q8.8 sensor samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one signed Q8.8 sample per request. Samples outside
//             [lower_limit, upper_limit] are flagged and not stored.
//   results : one request per sample, carrying the average over the last
//             WINDOW stored samples (or the sample itself when rejected
//             before anything is stored) and the rejected flag.
//   cfg     : index 0 writes upper_limit, index 1 writes lower_limit;
//             other indexes are dropped. Always ready; write only when idle.
// Flow: a stored sample passes through the update, start, divide and done
//   states; a rejected sample skips the update while samples are stored,
//   and with an empty store goes from idle straight to done. One sample at
//   a time: the input is ready again the cycle after the result is loaded.
// The result sits in an output register; the next sample is taken while it
//   waits. A stalled receiver holds the result, and a finished second result
//   waits inside the block until the register frees up.
// Reset clears the fill count, write position and running sum and loads the
//   default limits (100.0 and -40.0).
// ----------------------------------------------------------------------------
module range_checked_moving_average #(
    parameter int WINDOW = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    rcma_sample_if.sink samples,
    rcma_result_if.source results,
    rcma_cfg_if.sink    cfg
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = rcma_pkg::SAMPLE_W + CNT_W;

    rcma_pkg::state_t  state_reg, state_next;
    rcma_pkg::ctrl_t   ctrl;

    rcma_pkg::sample_t upper_reg, lower_reg;
    rcma_pkg::sample_t sample_reg;
    logic              rej_reg;
    rcma_pkg::sample_t res_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PTR_W-1:0]        wpos_reg, wpos_next;

    logic                    out_valid_reg;
    rcma_pkg::sample_t       out_avg_reg;
    logic                    out_rej_reg;

    logic                    accept;
    logic                    out_of_range;
    logic                    full;
    logic [rcma_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quotient;
    logic signed [SUM_W-1:0] old_ext;

    assign accept       = samples.valid && ctrl.in_ready;
    assign out_of_range = (samples.sample > upper_reg) || (samples.sample < lower_reg);
    assign full         = (count_reg == CNT_W'(WINDOW));
    assign old_ext      = full ? SUM_W'(signed'(ram_rdata)) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!out_of_range)
                    begin
                        state_next = rcma_pkg::ST_UPDATE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = rcma_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rcma_pkg::ST_START;
                    end
                end
            end
            rcma_pkg::ST_UPDATE: state_next = rcma_pkg::ST_START;
            rcma_pkg::ST_START:  state_next = rcma_pkg::ST_DIVIDE;
            rcma_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = rcma_pkg::ST_DONE;
                end
            end
            rcma_pkg::ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = rcma_pkg::ST_IDLE;
                end
            end
            default: state_next = rcma_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            rcma_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.ram_re   = 1'b1;
            end
            rcma_pkg::ST_UPDATE: ctrl.ram_we    = 1'b1;
            rcma_pkg::ST_START:  ctrl.div_start = 1'b1;
            rcma_pkg::ST_DIVIDE: ctrl = '0;
            rcma_pkg::ST_DONE:   ctrl.load_out  = !out_valid_reg || results.ready;
            default:             ctrl = '0;
        endcase
    end

    // window state update
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        wpos_next  = wpos_reg;
        if (ctrl.ram_we)
        begin
            // drop the oldest entry once the window is full
            sum_next = sum_reg - old_ext + SUM_W'(sample_reg);
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            wpos_next = (wpos_reg == PTR_W'(WINDOW - 1)) ? '0 : wpos_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcma_pkg::ST_IDLE;
            upper_reg     <= rcma_pkg::UPPER_RESET;
            lower_reg     <= rcma_pkg::LOWER_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            wpos_reg  <= wpos_next;
            if (cfg.valid && cfg.index == rcma_pkg::REG_UPPER)
            begin
                upper_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == rcma_pkg::REG_LOWER)
            begin
                lower_reg <= cfg.data;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= samples.sample;
            rej_reg    <= out_of_range;
            res_reg    <= samples.sample;
        end
        else if (div_done)
        begin
            res_reg <= div_quotient[rcma_pkg::SAMPLE_W-1:0];
        end
        if (ctrl.load_out)
        begin
            out_avg_reg <= res_reg;
            out_rej_reg <= rej_reg;
        end
    end

    rcma_ram #(
        .WIDTH (rcma_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (wpos_reg),
        .wdata (sample_reg),
        .re    (ctrl.ram_re),
        .raddr (wpos_reg),
        .rdata (ram_rdata)
    );

    rcma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign samples.ready    = ctrl.in_ready;
    assign cfg.ready        = 1'b1;
    assign results.valid    = out_valid_reg;
    assign results.average  = out_avg_reg;
    assign results.rejected = out_rej_reg;

endmodule

>>> design/rcma_checker.sv
// ----------------------------------------------------------------------------
// rcma_checker
// Port-level checks of the moving average, bound to the top level.
// ----------------------------------------------------------------------------
module rcma_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input rcma_pkg::sample_t average,
    input logic              rejected
);

    // a stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(average) && $stable(rejected))
        else $error("result changed while stalled");

    // one sample at a time: the input is not ready right after a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while busy");

    // a result never appears straight after a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared too early");

endmodule

bind range_checked_moving_average rcma_checker u_rcma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .average   (results.average),
    .rejected  (results.rejected)
);

>>> verif/tb_range_checked_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_checked_moving_average
// Self-checking bench for the range-checked moving average. Samples are
// driven from a pending queue and expected averages are computed at
// acceptance by a behavioral window model. Each returned result is compared
// with the oldest prediction. The run steps through several limit settings:
// reset defaults, full range, crossed, pinned to one value and narrow.
// Both handshake sides idle at random, and one long receiver stall is used
// to back up the block.
// ----------------------------------------------------------------------------
module tb_range_checked_moving_average;

    localparam int WINDOW      = 10;
    localparam int LATENCY     = 24;
    localparam int IDLE_PCT    = 37;
    localparam int LONG_STALL  = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    // indexes with no register behind them
    localparam rcma_pkg::cfg_idx_t REG_SPARE_2 = 2'd2;
    localparam rcma_pkg::cfg_idx_t REG_SPARE_3 = 2'd3;

    typedef struct packed {
        rcma_pkg::sample_t average;
        logic              rejected;
    } avg_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rcma_sample_if samples_if ();
    rcma_result_if results_if ();
    rcma_cfg_if    cfg_if ();

    range_checked_moving_average #(
        .WINDOW (WINDOW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // window model
    rcma_pkg::sample_t upper_lim;
    rcma_pkg::sample_t lower_lim;
    rcma_pkg::sample_t window_store [WINDOW];
    int      wr_pos;
    int      fill_cnt;
    int      run_sum;

    rcma_pkg::sample_t sample_queue [$];
    avg_result_t       avg_expected [$];

    int fail_cnt      = 0;
    int accepted_cnt  = 0;
    int result_cnt    = 0;
    int reject_cnt    = 0;
    int cfg_write_cnt = 0;
    int cycle_cnt     = 0;
    bit no_idle       = 1'b0;
    int stall_trigger = 0;
    int stall_seen    = 0;
    int stall_left    = 0;

    always #4 clk = ~clk;

    function automatic avg_result_t predict_average(rcma_pkg::sample_t s);
        avg_result_t r;
        if (s > upper_lim || s < lower_lim)
        begin
            r.rejected = 1'b1;
            r.average  = (fill_cnt > 0) ? rcma_pkg::sample_t'(run_sum / fill_cnt) : s;
        end
        else
        begin
            // drop the oldest entry once the window is full
            if (fill_cnt >= WINDOW)
                run_sum -= window_store[wr_pos];
            else
                fill_cnt++;
            window_store[wr_pos] = s;
            run_sum += s;
            wr_pos = (wr_pos + 1 >= WINDOW) ? 0 : wr_pos + 1;
            r.rejected = 1'b0;
            r.average  = rcma_pkg::sample_t'(run_sum / fill_cnt);
        end
        return r;
    endfunction

    // bias toward the limit edges, then the accepted band, then anything
    function automatic rcma_pkg::sample_t pick_sample();
        int pick;
        int lo;
        int hi;
        int v;
        lo   = lower_lim;
        hi   = upper_lim;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            case ($urandom_range(3))
                0:       v = hi;
                1:       v = hi + 1;
                2:       v = lo;
                default: v = lo - 1;
            endcase
        end
        else if (pick < 70 && lo <= hi)
            v = lo + int'($urandom_range(hi - lo));
        else
            v = int'($urandom_range(65535)) - 32768;
        if (v > 32767 || v < -32768)
            v = int'($urandom_range(65535)) - 32768;
        return rcma_pkg::sample_t'(v);
    endfunction

    task automatic report_failure(input string msg);
        if (fail_cnt < MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic queue_random(input int n);
        @(negedge clk);
        repeat (n)
            sample_queue.push_back(pick_sample());
    endtask

    // hold until every request is accepted and answered, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || samples_if.valid || avg_expected.size() != 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input rcma_pkg::cfg_idx_t idx, input rcma_pkg::sample_t value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == rcma_pkg::REG_UPPER)
            upper_lim <= value;
        else if (idx == rcma_pkg::REG_LOWER)
            lower_lim <= value;
        cfg_write_cnt++;
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                avg_expected.push_back(predict_average(samples_if.sample));
                accepted_cnt++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (sample_queue.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    samples_if.valid  <= 1'b1;
                    samples_if.sample <= sample_queue.pop_front();
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, loaded whenever the trigger count moves
    always @(posedge clk)
    begin
        if (stall_trigger != stall_seen)
        begin
            stall_seen <= stall_trigger;
            stall_left <= LONG_STALL;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_mon
        avg_result_t want;
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                result_cnt++;
                if (results_if.rejected)
                    reject_cnt++;
                if (avg_expected.size() == 0)
                begin
                    report_failure($sformatf("unexpected result: average %0d rejected %0b",
                                             results_if.average, results_if.rejected));
                end
                else
                begin
                    want = avg_expected.pop_front();
                    if (results_if.average !== want.average)
                        report_failure($sformatf("average expected %0d got %0d",
                                                 $signed(want.average), results_if.average));
                    if (results_if.rejected !== want.rejected)
                        report_failure($sformatf("rejected expected %0b got %0b",
                                                 want.rejected, results_if.rejected));
                end
            end
            results_if.ready <= (stall_left == 0) &&
                                (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int directed_vals [20];

        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        results_if.ready  = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = rcma_pkg::REG_UPPER;
        cfg_if.data       = '0;
        upper_lim         = rcma_pkg::UPPER_RESET;
        lower_lim         = rcma_pkg::LOWER_RESET;
        wr_pos            = 0;
        fill_cnt          = 0;
        run_sum           = 0;
        foreach (window_store[i])
            window_store[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // default limits: rejects on an empty store pass the sample through,
        // exact limit values are accepted, a reject with samples stored
        // returns the average, and the window fills and then overwrites
        directed_vals = '{32767, -32768, 25601, -10241, 25600, -10240, 0, 30000,
                          256, -256, 1, -1, 12800, -5000, 100, 7, 25599, -10239,
                          -32768, 21845};
        @(negedge clk);
        foreach (directed_vals[i])
            sample_queue.push_back(rcma_pkg::sample_t'(directed_vals[i]));
        wait_idle();

        queue_random(100);
        wait_idle();

        // full range with no idling on either side
        write_reg(rcma_pkg::REG_UPPER, 16'sh7FFF);
        write_reg(rcma_pkg::REG_LOWER, 16'sh8000);
        no_idle <= 1'b1;
        queue_random(100);
        wait_idle();
        no_idle <= 1'b0;

        // crossed limits reject everything; spare indexes must be dropped
        write_reg(REG_SPARE_2, 16'sh1234);
        write_reg(rcma_pkg::REG_UPPER, -16'sd256);
        write_reg(rcma_pkg::REG_LOWER, 16'sd256);
        write_reg(REG_SPARE_3, 16'sh8000);
        queue_random(40);
        wait_idle();

        // both limits pinned to the most negative value
        write_reg(rcma_pkg::REG_UPPER, 16'sh8000);
        write_reg(rcma_pkg::REG_LOWER, 16'sh8000);
        queue_random(40);
        wait_idle();

        // narrow band with the receiver held off while samples keep coming
        write_reg(rcma_pkg::REG_UPPER, 16'sd1280);
        write_reg(rcma_pkg::REG_LOWER, -16'sd1280);
        stall_trigger <= stall_trigger + 1;
        queue_random(120);
        wait_idle();

        // both limits pinned to the most positive value
        write_reg(rcma_pkg::REG_LOWER, 16'sh7FFF);
        write_reg(rcma_pkg::REG_UPPER, 16'sh7FFF);
        queue_random(30);
        wait_idle();

        write_reg(rcma_pkg::REG_UPPER, rcma_pkg::UPPER_RESET);
        write_reg(rcma_pkg::REG_LOWER, rcma_pkg::LOWER_RESET);
        queue_random(120);
        wait_idle();

        if (avg_expected.size() != 0)
            report_failure($sformatf("%0d results never arrived", avg_expected.size()));

        $display("run covered %0d samples, %0d of them rejected, across %0d register writes",
                 accepted_cnt, reject_cnt, cfg_write_cnt);
        $display("limits: default, full range, crossed, pinned low, narrow, pinned high;"
                 , " %0d results checked", result_cnt);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> range_checked_moving_average.f
design/rcma_pkg.sv
design/rcma_if.sv
design/rcma_ram.sv
design/rcma_div.sv
design/range_checked_moving_average.sv
design/rcma_checker.sv
verif/tb_range_checked_moving_average.sv
